FILE: design/rotary_cos_sin_generator_macros.svh
// Assertion helpers for the module that checks its own logic (rcsg_ctrl).
`ifndef ROTARY_COS_SIN_GENERATOR_MACROS_SVH
`define ROTARY_COS_SIN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define RCSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define RCSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rcsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rcsg_pkg;

	localparam int DEF_MAX_PAIRS     = 64;
	localparam int DEF_POSITION_BITS = 20;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 48;
	localparam int COUNT_W     = 7;
	localparam int TERMS       = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_RATIO   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_FREQ   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAIRS_IN_USE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_SCALE = 2'd3;

	localparam logic [32:0] RST_FREQ_RATIO   = 33'd3719318000;
	localparam logic [47:0] RST_FIRST_FREQ   = 48'd44798255814083;
	localparam logic [6:0]  RST_PAIRS_IN_USE = 7'd64;
	localparam logic [15:0] RST_OUTPUT_SCALE = 16'd4096;

	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PH_LO,
		ST_PH_HI,
		ST_NF_LO,
		ST_NF_HI,
		ST_SIN_X,
		ST_SIN_X2,
		ST_SIN_P,
		ST_SIN_Q,
		ST_SIN_C,
		ST_SIN_F,
		ST_SCALE_S,
		ST_SCALE_C,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PH_LO,
		OP_PH_HI,
		OP_NF_LO,
		OP_NF_HI,
		OP_SIN_X,
		OP_SIN_X2,
		OP_SIN_P,
		OP_SIN_Q,
		OP_SIN_C,
		OP_SIN_F,
		OP_SCALE_S,
		OP_SCALE_C
	} dp_op_t;

	typedef struct packed {
		dp_op_t             op;
		logic               wb;
		logic               load;
		logic               emit;
		logic [2:0]         term;
		logic               which;
		logic [COUNT_W-1:0] pair;
		logic               last;
	} dp_cmd_t;

	typedef struct packed {
		logic               out_blocked;
		logic [COUNT_W-1:0] pair_count;
	} dp_status_t;

	function automatic logic [7:0] term_div(input logic [2:0] idx);
		case (idx)
			3'd0: term_div = 8'd156;
			3'd1: term_div = 8'd110;
			3'd2: term_div = 8'd72;
			3'd3: term_div = 8'd42;
			3'd4: term_div = 8'd20;
			default: term_div = 8'd6;
		endcase
	endfunction

	// Reciprocals are floor(2^32 / divisor); the quotient may come out one short.
	function automatic logic [29:0] term_recip(input logic [2:0] idx);
		case (idx)
			3'd0: term_recip = 30'd27531841;
			3'd1: term_recip = 30'd39045157;
			3'd2: term_recip = 30'd59652323;
			3'd3: term_recip = 30'd102261126;
			3'd4: term_recip = 30'd214748364;
			default: term_recip = 30'd715827882;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: design/rcsg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rcsg_datapath
	import rcsg_pkg::*;
#(
	parameter int MAX_PAIRS     = DEF_MAX_PAIRS,
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [POSITION_BITS-1:0] position,
	input  wire dp_cmd_t                  cmd,
	output dp_status_t                    status,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [5:0]                    pair_index,
	output logic signed [15:0]            cos_value,
	output logic signed [15:0]            sin_value,
	output logic                          last
);

	logic [32:0] ratio_q;
	logic [47:0] first_q;
	logic [6:0]  pairs_q;
	logic [15:0] scale_q;

	logic [POSITION_BITS-1:0] pos_q;
	logic [47:0] f_q;
	logic [55:0] acc_q;
	logic [1:0]  quad_q;
	logic [29:0] r_q;
	logic [30:0] x_q;
	logic [31:0] x2_q;
	logic [30:0] t_q;
	logic [31:0] p_q;
	logic [29:0] q_q;
	logic [30:0] s_q;
	logic [30:0] c_q;
	logic [19:0] ms_q;
	logic [19:0] mc_q;
	logic [63:0] prod_q;

	logic        out_valid_q;
	logic [5:0]  pair_q;
	logic [15:0] cos_q;
	logic [15:0] sin_q;
	logic        last_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [30:0] u;
	logic [47:0] phase;
	logic [56:0] nf_sum;
	logic [48:0] nf;
	logic [31:0] rem;
	logic [30:0] q_fix;
	logic [31:0] fin;
	logic [30:0] mag;
	logic [46:0] scaled;
	logic [6:0]  count;

	function automatic logic [15:0] sat_out(input logic [19:0] m, input logic neg);
		logic [16:0] lim;
		lim = (m > 20'd32768) ? 17'd32768 : m[16:0];
		if (neg) begin
			sat_out = 16'(17'h10000 - lim);
		end else begin
			sat_out = (m > 20'd32767) ? 16'h7fff : m[15:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RST_FREQ_RATIO;
			first_q <= RST_FIRST_FREQ;
			pairs_q <= RST_PAIRS_IN_USE;
			scale_q <= RST_OUTPUT_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FREQ_RATIO:   ratio_q <= cfg_data[32:0];
				CFG_FIRST_FREQ:   first_q <= cfg_data[47:0];
				CFG_PAIRS_IN_USE: pairs_q <= cfg_data[6:0];
				CFG_OUTPUT_SCALE: scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pairs_q == 7'd0) begin
			count = 7'd1;
		end else if (pairs_q > 7'(MAX_PAIRS)) begin
			count = 7'(MAX_PAIRS);
		end else begin
			count = pairs_q;
		end
	end

	assign status.pair_count  = count;
	assign status.out_blocked = out_valid_q && out_stall;

	assign u = cmd.which ? (Q30_ONE - {1'b0, r_q}) : {1'b0, r_q};

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			OP_PH_LO: begin
				mul_a = 32'(pos_q);
				mul_b = {8'd0, f_q[23:0]};
			end
			OP_PH_HI: begin
				mul_a = 32'(pos_q);
				mul_b = {8'd0, f_q[47:24]};
			end
			OP_NF_LO: begin
				mul_a = ratio_q[31:0];
				mul_b = {8'd0, f_q[23:0]};
			end
			OP_NF_HI: begin
				mul_a = ratio_q[31:0];
				mul_b = {8'd0, f_q[47:24]};
			end
			OP_SIN_X: begin
				mul_a = {1'b0, u};
				mul_b = TWO_PI_Q29;
			end
			OP_SIN_X2: begin
				mul_a = {1'b0, x_q};
				mul_b = {1'b0, x_q};
			end
			OP_SIN_P: begin
				mul_a = x2_q;
				mul_b = {1'b0, t_q};
			end
			OP_SIN_Q: begin
				mul_a = p_q;
				mul_b = {2'd0, term_recip(cmd.term)};
			end
			OP_SIN_C: begin
				mul_a = {2'd0, q_q};
				mul_b = {24'd0, term_div(cmd.term)};
			end
			OP_SIN_F: begin
				mul_a = {1'b0, x_q};
				mul_b = {1'b0, t_q};
			end
			OP_SCALE_S: begin
				mul_a = {1'b0, s_q};
				mul_b = {16'd0, scale_q};
			end
			OP_SCALE_C: begin
				mul_a = {1'b0, c_q};
				mul_b = {16'd0, scale_q};
			end
			default: ;
		endcase
	end

	assign phase  = acc_q[47:0] + {prod_q[23:0], 24'd0};
	assign nf_sum = 57'(prod_q[55:0]) + 57'(acc_q[31:0]);
	assign nf     = 49'(nf_sum >> 8) + (ratio_q[32] ? {1'b0, f_q} : 49'd0);
	assign rem    = p_q - prod_q[31:0];
	assign q_fix  = 31'(q_q) + ((rem >= 32'(term_div(cmd.term))) ? 31'd1 : 31'd0);
	assign fin    = prod_q[61:30];
	assign mag    = (fin > 32'(Q30_ONE)) ? Q30_ONE : fin[30:0];
	assign scaled = prod_q[46:0] + 47'(64'd1 << 26);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			pos_q <= position;
			f_q   <= first_q;
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_PH_LO: acc_q <= prod_q[55:0];
				OP_PH_HI: begin
					quad_q <= phase[47:46];
					r_q    <= phase[45:16];
				end
				OP_NF_LO: acc_q <= 56'(prod_q[55:24]);
				OP_NF_HI: f_q <= nf[47:0];
				OP_SIN_X: x_q <= prod_q[61:31];
				OP_SIN_X2: begin
					x2_q <= prod_q[61:30];
					t_q  <= Q30_ONE;
				end
				OP_SIN_P: p_q <= prod_q[61:30];
				OP_SIN_Q: q_q <= prod_q[61:32];
				OP_SIN_C: t_q <= Q30_ONE - q_fix;
				OP_SIN_F: begin
					if (cmd.which) begin
						c_q <= mag;
					end else begin
						s_q <= mag;
					end
				end
				OP_SCALE_S: ms_q <= scaled[46:27];
				OP_SCALE_C: mc_q <= scaled[46:27];
				default: ;
			endcase
		end
		if (cmd.emit) begin
			pair_q <= 6'(cmd.pair);
			last_q <= cmd.last;
			case (quad_q)
				2'd0: begin
					sin_q <= sat_out(ms_q, 1'b0);
					cos_q <= sat_out(mc_q, 1'b0);
				end
				2'd1: begin
					sin_q <= sat_out(mc_q, 1'b0);
					cos_q <= sat_out(ms_q, 1'b1);
				end
				2'd2: begin
					sin_q <= sat_out(ms_q, 1'b1);
					cos_q <= sat_out(mc_q, 1'b1);
				end
				default: begin
					sin_q <= sat_out(mc_q, 1'b1);
					cos_q <= sat_out(ms_q, 1'b0);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign pair_index = pair_q;
	assign cos_value  = cos_q;
	assign sin_value  = sin_q;
	assign last       = last_q;

endmodule
`default_nettype wire

FILE: design/rcsg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rotary_cos_sin_generator_macros.svh"
module rcsg_ctrl
	import rcsg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        sub_q;
	logic [2:0]  term_q;
	logic        which_q;
	logic [COUNT_W-1:0] pair_q;
	logic        compute;
	logic        step;
	logic        is_last;

	assign compute = (state_q != ST_IDLE) && (state_q != ST_EMIT);
	assign step    = compute && sub_q;
	assign is_last = (pair_q + 7'd1) == status.pair_count;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_PH_LO;
			ST_PH_LO:   if (step) state_d = ST_PH_HI;
			ST_PH_HI:   if (step) state_d = ST_NF_LO;
			ST_NF_LO:   if (step) state_d = ST_NF_HI;
			ST_NF_HI:   if (step) state_d = ST_SIN_X;
			ST_SIN_X:   if (step) state_d = ST_SIN_X2;
			ST_SIN_X2:  if (step) state_d = ST_SIN_P;
			ST_SIN_P:   if (step) state_d = ST_SIN_Q;
			ST_SIN_Q:   if (step) state_d = ST_SIN_C;
			ST_SIN_C: begin
				if (step) begin
					state_d = (term_q == 3'(TERMS - 1)) ? ST_SIN_F : ST_SIN_P;
				end
			end
			ST_SIN_F:   if (step) state_d = which_q ? ST_SCALE_S : ST_SIN_X;
			ST_SCALE_S: if (step) state_d = ST_SCALE_C;
			ST_SCALE_C: if (step) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_blocked) begin
					state_d = is_last ? ST_IDLE : ST_PH_LO;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.wb    = step;
		cmd.term  = term_q;
		cmd.which = which_q;
		cmd.pair  = pair_q;
		cmd.last  = is_last;
		case (state_q)
			ST_IDLE:    cmd.load = in_valid;
			ST_PH_LO:   cmd.op = OP_PH_LO;
			ST_PH_HI:   cmd.op = OP_PH_HI;
			ST_NF_LO:   cmd.op = OP_NF_LO;
			ST_NF_HI:   cmd.op = OP_NF_HI;
			ST_SIN_X:   cmd.op = OP_SIN_X;
			ST_SIN_X2:  cmd.op = OP_SIN_X2;
			ST_SIN_P:   cmd.op = OP_SIN_P;
			ST_SIN_Q:   cmd.op = OP_SIN_Q;
			ST_SIN_C:   cmd.op = OP_SIN_C;
			ST_SIN_F:   cmd.op = OP_SIN_F;
			ST_SCALE_S: cmd.op = OP_SCALE_S;
			ST_SCALE_C: cmd.op = OP_SCALE_C;
			ST_EMIT:    cmd.emit = !status.out_blocked;
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q   <= 1'b0;
			term_q  <= 3'd0;
			which_q <= 1'b0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			sub_q   <= compute ? ~sub_q : 1'b0;
			if (state_q == ST_IDLE && in_valid) begin
				pair_q <= '0;
			end else if (cmd.emit) begin
				pair_q <= pair_q + 7'd1;
			end
			if (step && state_q == ST_NF_HI) begin
				which_q <= 1'b0;
			end else if (step && state_q == ST_SIN_F) begin
				which_q <= 1'b1;
			end
			if (step && state_q == ST_SIN_X2) begin
				term_q <= 3'd0;
			end else if (step && state_q == ST_SIN_C) begin
				term_q <= term_q + 3'd1;
			end
		end
	end

	`RCSG_ASSERT_NOW(a_emit_free, cmd.emit, !status.out_blocked, "word emitted into full output")
	`RCSG_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state_q == ST_IDLE,
		"no return to idle after final pair")
	`RCSG_ASSERT_NOW(a_pair_range, state_q != ST_IDLE, pair_q < status.pair_count,
		"pair counter past pair count")
	`RCSG_ASSERT_NEXT(a_terms_done, state_q == ST_SIN_C && step && term_q == 3'(TERMS - 1),
		state_q == ST_SIN_F, "series did not finish after last term")

endmodule
`default_nettype wire

FILE: design/rotary_cos_sin_generator.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    position
// output    out_valid / out_stall  pair_index, cos_value, sin_value, last
// config    cfg_we                 cfg_index, cfg_data
//
// Each pair runs 48 steps on the one shared 32x32 multiplier (phase, next frequency,
// two six-term sine series, two scalings) and then an emit step.
// A position runs this for every pair in use before the next position is taken.
// The output register lets the next pair compute while a word waits; a held word stalls
// only the emit step. Reset restores the register defaults and returns to idle.
`timescale 1ns / 1ps
`default_nettype none
module rotary_cos_sin_generator
	import rcsg_pkg::*;
#(
	parameter int MAX_PAIRS     = DEF_MAX_PAIRS,
	parameter int POSITION_BITS = DEF_POSITION_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [POSITION_BITS-1:0] position,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [5:0]                    pair_index,
	output logic signed [15:0]            cos_value,
	output logic signed [15:0]            sin_value,
	output logic                          last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	rcsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rcsg_datapath #(
		.MAX_PAIRS     (MAX_PAIRS),
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.position   (position),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pair_index (pair_index),
		.cos_value  (cos_value),
		.sin_value  (sin_value),
		.last       (last)
	);

endmodule
`default_nettype wire

FILE: bench/rotary_cos_sin_generator_test.sv
`timescale 1ns / 1ps
module rotary_cos_sin_generator_test;
	import rcsg_pkg::*;

	typedef struct {
		logic [5:0]  pair;
		logic [15:0] cosv;
		logic [15:0] sinv;
		logic        fin;
	} pair_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [19:0]            position;
	logic                   out_valid;
	logic                   out_stall;
	logic [5:0]             pair_index;
	logic signed [15:0]     cos_value;
	logic signed [15:0]     sin_value;
	logic                   last;

	logic [32:0] ratio_q;
	logic [47:0] first_q;
	logic [6:0]  pairs_q;
	logic [15:0] scale_q;

	logic [19:0] pending_positions[$];
	pair_word_t  expected_pairs[$];
	bit          took;
	bit          calm;
	int          errors;
	int          positions_taken;
	int          pairs_checked;
	int          quiet_cycles;

	rotary_cos_sin_generator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.position(position), .out_valid(out_valid), .out_stall(out_stall),
		.pair_index(pair_index), .cos_value(cos_value), .sin_value(sin_value),
		.last(last)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned quarter_sine(longint unsigned u);
		longint unsigned x, x2, t;
		int divs[6];
		divs = '{156, 110, 72, 42, 20, 6};
		x = (u * 64'd3373259426) >> 31;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 6; i++)
			t = (64'd1 << 30) - (((x2 * t) >> 30) / divs[i]);
		t = (x * t) >> 30;
		return (t > (64'd1 << 30)) ? (64'd1 << 30) : t;
	endfunction

	function automatic logic [15:0] scaled_mag(longint unsigned mag, bit neg);
		longint unsigned m;
		m = (mag * scale_q + (64'd1 << 26)) >> 27;
		if (neg) begin
			if (m > 32768)
				m = 32768;
			return 16'(17'h10000 - m);
		end
		if (m > 32767)
			m = 32767;
		return 16'(m);
	endfunction

	task automatic predict_rotation(logic [19:0] pos);
		int n;
		logic [47:0] f;
		logic [80:0] prod;
		logic [67:0] ph;
		longint unsigned a, r, s, c;
		pair_word_t w;
		n = pairs_q;
		if (n < 1)
			n = 1;
		if (n > 64)
			n = 64;
		f = first_q;
		for (int j = 0; j < n; j++) begin
			ph = pos * f;
			a = ph[47:16];
			r = a & ((64'd1 << 30) - 1);
			s = quarter_sine(r);
			c = quarter_sine((64'd1 << 30) - r);
			w.pair = j[5:0];
			w.fin = (j + 1 == n);
			case (a >> 30)
				0: begin w.sinv = scaled_mag(s, 0); w.cosv = scaled_mag(c, 0); end
				1: begin w.sinv = scaled_mag(c, 0); w.cosv = scaled_mag(s, 1); end
				2: begin w.sinv = scaled_mag(s, 1); w.cosv = scaled_mag(c, 1); end
				default: begin w.sinv = scaled_mag(c, 1); w.cosv = scaled_mag(s, 0); end
			endcase
			expected_pairs.push_back(w);
			prod = f * ratio_q;
			f = prod[79:32];
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_FREQ_RATIO: ratio_q = data[32:0];
			CFG_FIRST_FREQ: first_q = data[47:0];
			CFG_PAIRS_IN_USE: pairs_q = data[6:0];
			default: scale_q = data[15:0];
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending_positions.size() != 0 || in_valid || expected_pairs.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	always @(posedge clk) begin
		took = 0;
		if (arst_n && in_valid && !in_stall) begin
			took = 1;
			positions_taken++;
			predict_rotation(position);
		end
		if (arst_n && out_valid && !out_stall) begin
			pairs_checked++;
			if (expected_pairs.size() == 0) begin
				errors++;
				$display("%t: unexpected word pair %0d cos %0d sin %0d last %0b",
					$time, pair_index, cos_value, sin_value, last);
			end else begin
				pair_word_t w;
				w = expected_pairs.pop_front();
				if (w.pair !== pair_index || w.cosv !== cos_value ||
						w.sinv !== sin_value || w.fin !== last) begin
					errors++;
					$display("%t: mismatch expected pair %0d cos %0d sin %0d last %0b,",
						$time, w.pair, $signed(w.cosv), $signed(w.sinv), w.fin);
					$display("    actual pair %0d cos %0d sin %0d last %0b",
						pair_index, cos_value, sin_value, last);
				end
			end
		end
		if (took || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > 20000) begin
			$display("Timeout: no word accepted for %0d cycles.", quiet_cycles);
			$display("rotary_cos_sin_generator regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= !calm && ($urandom_range(99) < 27);
			if (!in_valid || took) begin
				if (pending_positions.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
					in_valid <= 1;
					position <= pending_positions.pop_front();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	initial begin
		logic [19:0] edge_positions[6];
		cfg_we = 0;
		cfg_index = CFG_FREQ_RATIO;
		cfg_data = 0;
		in_valid = 0;
		position = 0;
		out_stall = 0;
		calm = 0;
		errors = 0;
		positions_taken = 0;
		pairs_checked = 0;
		quiet_cycles = 0;
		ratio_q = RST_FREQ_RATIO;
		first_q = RST_FIRST_FREQ;
		pairs_q = RST_PAIRS_IN_USE;
		scale_q = RST_OUTPUT_SCALE;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		edge_positions = '{20'd0, 20'd1, 20'hFFFFF, 20'h80000, 20'h55555, 20'hAAAAA};
		foreach (edge_positions[i])
			pending_positions.push_back(edge_positions[i]);
		drain();

		write_reg(CFG_PAIRS_IN_USE, 48'd0);
		write_reg(CFG_FREQ_RATIO, 48'd0);
		write_reg(CFG_FIRST_FREQ, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_OUTPUT_SCALE, 48'd65535);
		foreach (edge_positions[i])
			pending_positions.push_back(edge_positions[i]);
		for (int i = 0; i < 8; i++)
			pending_positions.push_back(20'($urandom));
		drain();

		write_reg(CFG_PAIRS_IN_USE, 48'd127);
		write_reg(CFG_FREQ_RATIO, 48'h1_FFFF_FFFF);
		write_reg(CFG_FIRST_FREQ, 48'({$urandom, $urandom}));
		write_reg(CFG_OUTPUT_SCALE, 48'd0);
		pending_positions.push_back(20'hFFFFF);
		pending_positions.push_back(20'($urandom));
		drain();

		write_reg(CFG_PAIRS_IN_USE, 48'hFFFF_FFFF_FF83);
		write_reg(CFG_FREQ_RATIO, 48'hFFFF_0000_0000 | 48'd1 << 32);
		write_reg(CFG_FIRST_FREQ, 48'd1);
		write_reg(CFG_OUTPUT_SCALE, 48'hFFFF_FFFF_1000);
		pending_positions.push_back(20'hFFFFF);
		pending_positions.push_back(20'd3);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			write_reg(CFG_PAIRS_IN_USE, 48'($urandom_range(1, 4)));
			write_reg(CFG_FREQ_RATIO, 48'({$urandom, $urandom} & 64'h1_FFFF_FFFF));
			write_reg(CFG_FIRST_FREQ, 48'({$urandom, $urandom}));
			write_reg(CFG_OUTPUT_SCALE, (ph % 2) ? 48'($urandom_range(65535)) : 48'd4096);
			for (int i = 0; i < 31; i++)
				pending_positions.push_back(20'($urandom));
			drain();
		end
		calm = 0;

		$display("Covered %0d positions and %0d pair words across edge, wrapped and random",
			positions_taken, pairs_checked);
		$display("register settings, with random stalls on both sides.");
		if (errors == 0)
			$display("rotary_cos_sin_generator regression: pass");
		else
			$display("rotary_cos_sin_generator regression: fail");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/rcsg_pkg.sv
design/rcsg_datapath.sv
design/rcsg_ctrl.sv
design/rotary_cos_sin_generator.sv
bench/rotary_cos_sin_generator_test.sv
